// File: rtl/sorted_unique_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted unique priority queue unit
// Concurrent checks on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define SUPQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("supq check failed");

// when ante holds, cons must hold at the same edge
`define SUPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("supq check failed");

// when ante holds, cons must hold at the next edge
`define SUPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("supq check failed");

`else

`define SUPQ_ASSERT_ALWAYS(label, cond)
`define SUPQ_ASSERT_IMPL(label, ante, cons)
`define SUPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/supq_pkg.sv
// ----------------------------------------------------------------------------
// supq_pkg
// Sizes, codes and types shared by the priority queue cells and the top level.
// ----------------------------------------------------------------------------
package supq_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned KEY_IO_W   = 16;  // width of the key ports
  localparam int unsigned COUNT_IO_W = 7;   // width of the entry count port
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    count_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp;  // compare the broadcast key, register the flags
    logic ins;  // open a gap at the first non-greater cell
    logic del;  // close the gap over the matching cell
  } supq_cell_ctl_t;

  // what a cell shows to its neighbors and to the sequencer
  typedef struct packed {
    logic valid;
    logic gt;   // valid and stored key above the compared key
    logic eq;   // valid and stored key equal to the compared key
  } supq_cell_stat_t;

endpackage

// File: rtl/supq_cell.sv
// ----------------------------------------------------------------------------
// supq_cell
// One slot of the sorted chain: holds a key and a valid bit, compares the
// broadcast key and loads from itself, its neighbors or the broadcast key.
// ----------------------------------------------------------------------------
module supq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  supq_pkg::supq_cell_ctl_t ctl_i,
  input  supq_pkg::key_t           bc_key_i,
  input  supq_pkg::key_t           left_key_i,
  input  supq_pkg::supq_cell_stat_t left_stat_i,
  input  supq_pkg::key_t           right_key_i,
  input  supq_pkg::supq_cell_stat_t right_stat_i,
  output supq_pkg::key_t           key_o,
  output supq_pkg::supq_cell_stat_t stat_o
);
  import supq_pkg::*;

  key_t key_q, key_d;
  logic valid_q, valid_d;
  logic gt_q, gt_d;
  logic eq_q, eq_d;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    gt_d    = gt_q;
    eq_d    = eq_q;
    if (ctl_i.cmp) begin
      gt_d = valid_q && (key_q > bc_key_i);
      eq_d = valid_q && (key_q == bc_key_i);
    end else if (ctl_i.ins && !gt_q) begin
      if (left_stat_i.gt) begin
        // first cell not above the new key takes it
        key_d   = bc_key_i;
        valid_d = 1'b1;
      end else begin
        key_d   = left_key_i;
        valid_d = left_stat_i.valid;
      end
    end else if (ctl_i.del && !gt_q) begin
      key_d   = right_key_i;
      valid_d = right_stat_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      gt_q    <= gt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o        = key_q;
  assign stat_o.valid = valid_q;
  assign stat_o.gt    = gt_q;
  assign stat_o.eq    = eq_q;

endmodule

// File: rtl/sorted_unique_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_unique_priority_queue_unit
// Set of unique keys kept in descending order in a chain of shift cells.
// ----------------------------------------------------------------------------
// A request (func_i, key_i) is taken at a rising edge with start high and
// busy low. Every request has a compare step and a shift step: at the accept edge all cells
// compare key_i in parallel against their stored key, and at the next edge
// the cells shift one place toward the tail (insert) or the head (delete).
// busy is high for the one cycle between those edges, so a new request can
// be taken in the cycle right after, but not while one is in flight. Each
// request gives exactly one result: done_o is high for one cycle, the cycle
// after the shift, with status_o, head_key_o, entry_count_o and is_empty_o
// showing the store after that request. The receiver cannot stall; the
// result must be captured in that cycle. A new request may be started in
// the same cycle as done_o. Status: done, duplicate (insert of a stored
// key, checked ahead of full), not found (delete of an absent key), full.
// head_key_o reads zero when the store is empty.
// ----------------------------------------------------------------------------
`include "sorted_unique_priority_queue_unit_assert.svh"

module sorted_unique_priority_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [supq_pkg::KEY_IO_W-1:0]       key_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [supq_pkg::KEY_IO_W-1:0]       head_key_o,
  output logic [supq_pkg::COUNT_IO_W-1:0]     entry_count_o,
  output logic                                is_empty_o
);
  import supq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_e;

  state_e         state_q;
  logic           done_q;
  status_e        status_q;
  count_t         count_q;
  key_t           req_key_q;
  func_e          func_q;

  key_t           in_key;
  key_t           bc_key;
  logic           accept;
  supq_cell_ctl_t ctl;

  // chain wiring
  key_t            cell_key  [CAPACITY];
  supq_cell_stat_t cell_stat [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] eq_vec;

  logic    found;
  logic    full;
  status_e status_d;
  count_t  count_d;

  // request key trimmed or extended to the stored key width
  if (KEY_BITS <= KEY_IO_W) begin : g_key_narrow
    assign in_key = key_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign in_key = {{(KEY_BITS-KEY_IO_W){1'b0}}, key_i};
  end

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q == S_SHIFT);
  // compare uses the live key, the shift uses the latched one
  assign bc_key = (state_q == S_IDLE) ? in_key : req_key_q;

  assign found = |eq_vec;
  assign full  = (count_q == count_t'(CAPACITY));

  always_comb begin
    ctl     = '0;
    ctl.cmp = accept;
    ctl.ins = (state_q == S_SHIFT) && (func_q == FUNC_INSERT) && !found && !full;
    ctl.del = (state_q == S_SHIFT) && (func_q == FUNC_DELETE) && found;
  end

  always_comb begin
    status_d = ST_DONE;
    count_d  = count_q;
    if (func_q == FUNC_INSERT) begin
      if (found) begin
        status_d = ST_DUPLICATE;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + count_t'(1);
      end
    end else begin
      if (!found) begin
        status_d = ST_NOT_FOUND;
      end else begin
        count_d = count_q - count_t'(1);
      end
    end
  end

  // the cell chain; cell 0 is the head
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    key_t            left_key;
    supq_cell_stat_t left_stat;
    key_t            right_key;
    supq_cell_stat_t right_stat;

    if (g == 0) begin : g_head
      // the head sees an imaginary greater neighbor
      assign left_key  = '0;
      assign left_stat = '{valid: 1'b0, gt: 1'b1, eq: 1'b0};
    end else begin : g_mid_left
      assign left_key  = cell_key[g-1];
      assign left_stat = cell_stat[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_key  = '0;
      assign right_stat = '0;
    end else begin : g_mid_right
      assign right_key  = cell_key[g+1];
      assign right_stat = cell_stat[g+1];
    end

    supq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .bc_key_i     (bc_key),
      .left_key_i   (left_key),
      .left_stat_i  (left_stat),
      .right_key_i  (right_key),
      .right_stat_i (right_stat),
      .key_o        (cell_key[g]),
      .stat_o       (cell_stat[g])
    );

    assign valid_vec[g] = cell_stat[g].valid;
    assign eq_vec[g]    = cell_stat[g].eq;
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      status_q  <= ST_DONE;
      count_q   <= '0;
      req_key_q <= '0;
      func_q    <= FUNC_INSERT;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_key_q <= in_key;
            func_q    <= func_e'(func_i);
            state_q   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          status_q <= status_d;
          count_q  <= count_d;
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign is_empty_o = !cell_stat[0].valid;

  if (KEY_BITS <= KEY_IO_W) begin : g_head_narrow
    assign head_key_o = cell_stat[0].valid
                      ? {{(KEY_IO_W-KEY_BITS){1'b0}}, cell_key[0]} : '0;
  end else begin : g_head_wide
    assign head_key_o = cell_stat[0].valid ? cell_key[0][KEY_IO_W-1:0] : '0;
  end

  if (CNT_W <= COUNT_IO_W) begin : g_cnt_narrow
    assign entry_count_o = {{(COUNT_IO_W-CNT_W){1'b0}}, count_q};
  end else begin : g_cnt_wide
    assign entry_count_o = count_q[COUNT_IO_W-1:0];
  end

  // count tracks the occupied cells
  `SUPQ_ASSERT_ALWAYS(a_count_matches, $countones(valid_vec) == int'(count_q))
  // occupied cells form a prefix from the head
  `SUPQ_ASSERT_ALWAYS(a_valid_prefix, (valid_vec & (valid_vec + 1'b1)) == '0)
  // keys are unique, so at most one cell matches
  `SUPQ_ASSERT_ALWAYS(a_single_match, $onehot0(eq_vec))
  // a result follows every accepted request
  `SUPQ_ASSERT_NEXT(a_result_follows, busy, done_o)
  // never shift both ways at once
  `SUPQ_ASSERT_IMPL(a_ctl_exclusive, ctl.ins || ctl.del, ctl.ins != ctl.del)

endmodule
